/* hw/rtl/dtw_distance_2d_core_defines.svh */
// ---------------------------------------------------------------------------
// DTW distance core assertion macros
// Shared property forms for the concurrent checks of the core.
// ---------------------------------------------------------------------------
`ifndef DTW_DISTANCE_2D_CORE_DEFINES_SVH
`define DTW_DISTANCE_2D_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DTWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DTWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dtwd_pkg.sv */
// ---------------------------------------------------------------------------
// DTW distance package
// Sizes, point type and cell constants shared by the core's modules.
// ---------------------------------------------------------------------------
package dtwd_pkg;

    localparam int MAX_LEN    = 256;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int DIST_W = 48;
    localparam int CELL_W = DIST_W + 1;

    // Squared sum is 2*COORD_BITS+1 bits; the radicand is padded to an even width
    localparam int SUM_W  = 2 * COORD_BITS + 1;
    localparam int RAD_W  = SUM_W + 1 + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;

    localparam logic [CELL_W-1:0] CELL_ZERO   = '0;
    localparam logic [CELL_W-1:0] UNREACHABLE = {1'b1, {DIST_W{1'b0}}};
    localparam logic [CELL_W-1:0] DIST_MAX    = {1'b0, {DIST_W{1'b1}}};

    // Sequence tags of the operation field
    localparam logic OP_A = 1'b0;
    localparam logic OP_B = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

endpackage

/* hw/rtl/dtwd_ram.sv */
// ---------------------------------------------------------------------------
// DTW generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module dtwd_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then read; the read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/dtwd_dist.sv */
// ---------------------------------------------------------------------------
// DTW point distance unit
// Squares the coordinate differences, then takes the integer square root of
// the scaled sum one result bit per cycle.
// ---------------------------------------------------------------------------
module dtwd_dist
    import dtwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  point_t            pa,
    input  point_t            pb,
    output logic              done,
    output logic [ROOT_W-1:0] cost
);

    localparam int STEP_W = $clog2(ROOT_W + 1);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_SQ   = 4'b0010,
        D_SUM  = 4'b0100,
        D_ROOT = 4'b1000
    } dstate_t;

    dstate_t                  state_reg, state_next;
    logic [COORD_BITS:0]      adx_reg, ady_reg;
    logic [2*COORD_BITS-1:0]  sqx_reg, sqy_reg;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [ROOT_W+1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     done_reg, done_next;

    logic signed [COORD_BITS:0] dx, dy;
    logic [ROOT_W+3:0]          rem_t, trial, rem_diff;
    logic [2*COORD_BITS+1:0]    sqx_full, sqy_full;

    // Differences and the squares of their magnitudes
    always_comb
    begin
        dx = {pa.x[COORD_BITS-1], pa.x} - {pb.x[COORD_BITS-1], pb.x};
        dy = {pa.y[COORD_BITS-1], pa.y} - {pb.y[COORD_BITS-1], pb.y};
        sqx_full = adx_reg * adx_reg;
        sqy_full = ady_reg * ady_reg;
    end

    // One digit of the square root
    always_comb
    begin
        rem_t    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        rem_diff = rem_t - trial;
    end

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = D_SQ;
                end
            end
            D_SQ:
            begin
                state_next = D_SUM;
            end
            D_SUM:
            begin
                rad_next   = {1'b0, ({1'b0, sqx_reg} + {1'b0, sqy_reg}),
                              {(2*FRAC_BITS){1'b0}}};
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                state_next = D_ROOT;
            end
            D_ROOT:
            begin
                rad_next = rad_reg << 2;
                if (rem_t >= trial)
                begin
                    rem_next  = rem_diff[ROOT_W+1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t[ROOT_W+1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            adx_reg <= dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
            ady_reg <= dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
        end
        if (state_reg == D_SQ)
        begin
            sqx_reg <= sqx_full[2*COORD_BITS-1:0];
            sqy_reg <= sqy_full[2*COORD_BITS-1:0];
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign cost = root_reg;

endmodule

/* hw/rtl/dtw_distance_2d_core.sv */
// ---------------------------------------------------------------------------
// DTW distance core
// Point stores, one-row cost memory and the table sequencer.
// ---------------------------------------------------------------------------
// Points load at one per cycle while the core is idle, also while a result
// waits. The final B point starts the table fill, during which the input is
// stalled: the cost row is set up, then for each A point a row of count_b
// cells is filled, each cell waiting on the bit-serial square root of its
// distance. An error result (empty A or overflow) skips the fill and goes
// straight to the output.
`include "dtw_distance_2d_core_defines.svh"

module dtw_distance_2d_core
    import dtwd_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic                         last_point,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [DIST_W-1:0]            warp_distance,
    output logic                         saturated,
    output logic                         size_error
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_INIT = 8'b00000010,
        S_ROW  = 8'b00000100,
        S_ROWL = 8'b00001000,
        S_RD   = 8'b00010000,
        S_GO   = 8'b00100000,
        S_WAIT = 8'b01000000,
        S_EMIT = 8'b10000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_a_reg, count_a_next;
    logic [CNT_W-1:0]  count_b_reg, count_b_next;
    logic              a_complete_reg, a_complete_next;
    logic              overflowed_reg, overflowed_next;
    logic              err_reg, err_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [CELL_W-1:0] diag_reg, left_reg, min_reg;
    point_t            pa_reg;

    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              sat_reg, lerr_reg;

    logic              in_acc, out_free, load_out;
    logic              a_we, b_we, c_we;
    logic [CNT_W-1:0]  c_waddr, c_raddr;
    logic [CELL_W-1:0] c_wdata, c_rdata, cell_min, cell_sat;
    logic [CELL_W:0]   cell_sum;
    logic [IDX_W-1:0]  b_raddr;
    point_t            pin, a_rdata, b_rdata;
    logic              dist_start, dist_done;
    logic [ROOT_W-1:0] dist_cost;

    assign pin      = '{x: coord_x, y: coord_y};
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == S_EMIT) && out_free;
    assign a_we     = in_acc && (operation == OP_A) && !a_complete_reg
                      && (count_a_reg < CNT_W'(MAX_LEN));
    assign b_we     = in_acc && (operation == OP_B) && (count_b_reg < CNT_W'(MAX_LEN));
    assign b_raddr  = IDX_W'(col_reg - 1'b1);

    // Point stores
    dtwd_ram #(.DEPTH(MAX_LEN), .WIDTH(2 * COORD_BITS)) u_points_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (count_a_reg[IDX_W-1:0]),
        .wdata (pin),
        .raddr (row_reg),
        .rdata (a_rdata)
    );

    dtwd_ram #(.DEPTH(MAX_LEN), .WIDTH(2 * COORD_BITS)) u_points_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (count_b_reg[IDX_W-1:0]),
        .wdata (pin),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Previous row of the warping table
    dtwd_ram #(.DEPTH(MAX_LEN + 1), .WIDTH(CELL_W)) u_cost_row (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    dtwd_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .pa    (pa_reg),
        .pb    (b_rdata),
        .done  (dist_done),
        .cost  (dist_cost)
    );

    // Least neighbour and saturating cell sum
    always_comb
    begin
        cell_min = (c_rdata < left_reg) ? c_rdata : left_reg;
        cell_min = (diag_reg < cell_min) ? diag_reg : cell_min;
        cell_sum = {1'b0, min_reg} + (CELL_W+1)'(dist_cost);
        cell_sat = (cell_sum > {1'b0, DIST_MAX}) ? DIST_MAX : cell_sum[CELL_W-1:0];
    end

    assign dist_start = (state_reg == S_GO);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        a_complete_next = a_complete_reg;
        overflowed_next = overflowed_reg;
        err_next        = err_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        c_we            = 1'b0;
        c_waddr         = col_reg;
        c_wdata         = cell_sat;
        c_raddr         = col_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (operation == OP_A) && !a_complete_reg)
                begin
                    if (a_we)
                    begin
                        count_a_next = count_a_reg + 1'b1;
                    end
                    else
                    begin
                        overflowed_next = 1'b1;
                    end
                    a_complete_next = last_point;
                end
                if (in_acc && (operation == OP_B))
                begin
                    if (b_we)
                    begin
                        count_b_next = count_b_reg + 1'b1;
                    end
                    else
                    begin
                        overflowed_next = 1'b1;
                    end
                    if (last_point)
                    begin
                        err_next = (count_a_reg == '0) || overflowed_next;
                        col_next = '0;
                        state_next = err_next ? S_EMIT : S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                c_we    = 1'b1;
                c_wdata = (col_reg == '0) ? CELL_ZERO : UNREACHABLE;
                col_next = col_reg + 1'b1;
                if (col_reg == count_b_reg)
                begin
                    row_next   = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                c_raddr    = '0;
                state_next = S_ROWL;
            end
            S_ROWL:
            begin
                c_we       = 1'b1;
                c_waddr    = '0;
                c_wdata    = UNREACHABLE;
                col_next   = CNT_W'(1);
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_GO;
            end
            S_GO:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (dist_done)
                begin
                    c_we = 1'b1;
                    if (col_reg == count_b_reg)
                    begin
                        if (CNT_W'(row_reg) + 1'b1 == count_a_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            state_next = S_ROW;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    count_a_next    = '0;
                    count_b_next    = '0;
                    a_complete_next = 1'b0;
                    overflowed_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            a_complete_reg <= 1'b0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            a_complete_reg <= a_complete_next;
            overflowed_reg <= overflowed_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table datapath and result register
    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        col_reg <= col_next;
        row_reg <= row_next;
        if (state_reg == S_ROWL)
        begin
            diag_reg <= c_rdata;
            pa_reg   <= a_rdata;
            left_reg <= UNREACHABLE;
        end
        if (state_reg == S_GO)
        begin
            min_reg  <= cell_min;
            diag_reg <= c_rdata;
        end
        if (state_reg == S_WAIT && dist_done)
        begin
            left_reg <= cell_sat;
        end
        if (load_out)
        begin
            dist_reg <= err_reg ? '0 : left_reg[DIST_W-1:0];
            sat_reg  <= !err_reg && (left_reg[DIST_W-1:0] == DIST_MAX[DIST_W-1:0]);
            lerr_reg <= err_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign warp_distance = dist_reg;
    assign saturated     = sat_reg;
    assign size_error    = lerr_reg;

    `DTWD_ASSERT_NOW(a_dist_only_wait, dist_done, state_reg == S_WAIT, "root done outside wait")
    `DTWD_ASSERT_NOW(a_count_a_bound, 1'b1, count_a_reg <= CNT_W'(MAX_LEN), "A count too big")
    `DTWD_ASSERT_NOW(a_count_b_bound, 1'b1, count_b_reg <= CNT_W'(MAX_LEN), "B count too big")
    `DTWD_ASSERT_NEXT(a_clear_after_emit, load_out, (count_a_reg == '0) && !overflowed_reg, "not cleared")
    `DTWD_ASSERT_NOW(a_rise_from_emit, $rose(out_valid_reg), $past(state_reg) == S_EMIT, "stray result")

endmodule

/* sim/tb_dtw_distance_2d_core.sv */
// ---------------------------------------------------------------------------
// DTW distance core testbench
// Drives A and B point trajectories into the core, with random idle and stall
// on both sides, and checks each warp distance against a built-in model of
// the warping table: directed corner cases first, then random trajectories.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dtw_distance_2d_core;
    import dtwd_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int RANDOM_ITEMS = 460;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              sat;
        logic              err;
    } warp_result_t;

    typedef struct packed {
        logic            op;
        logic [15:0]     x;
        logic [15:0]     y;
        logic            last;
        logic            typed;
        logic [DIST_W-1:0] distance;
        logic            err;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         operation;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         last_point;
    logic                         out_valid;
    logic                         out_stall;
    logic [DIST_W-1:0]            warp_distance;
    logic                         saturated;
    logic                         size_error;

    // model state of the core
    point_t            store_a [0:MAX_LEN-1];
    point_t            store_b [0:MAX_LEN-1];
    logic [CELL_W-1:0] cost_cells [0:MAX_LEN];
    int                num_a;
    int                num_b;
    bit                a_done;
    bit                overflow_seen;

    warp_result_t expected_q[$];
    int  mismatches = 0;
    bit  quiet;
    bit  hold_off_req;
    int  stall_count;
    int  idle_cycles = 0;

    stim_row_t dir_tab [0:16] = '{
        '{OP_B, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'd0,    1'b1},
        '{OP_A, 16'h0000, 16'h0000, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h0003, 16'h0004, 1'b1, 1'b1, 48'd1280, 1'b0},
        '{OP_A, 16'h8000, 16'h8000, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h7fff, 16'h7fff, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_A, 16'h7fff, 16'h8000, 1'b0, 1'b0, 48'd0,    1'b0},
        '{OP_A, 16'hffff, 16'h0005, 1'b0, 1'b0, 48'd0,    1'b0},
        '{OP_A, 16'h0000, 16'hffff, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_A, 16'h1234, 16'h5678, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h8000, 16'h7fff, 1'b0, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h5555, 16'haaaa, 1'b0, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h0001, 16'h0001, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h0003, 16'h0004, 1'b0, 1'b0, 48'd0,    1'b0},
        '{OP_A, 16'h0000, 16'h0000, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h0000, 16'h0000, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_A, 16'h0002, 16'h0002, 1'b1, 1'b0, 48'd0,    1'b0},
        '{OP_B, 16'h0002, 16'h0002, 1'b1, 1'b1, 48'd0,    1'b0}
    };

    dtw_distance_2d_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .last_point    (last_point),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .warp_distance (warp_distance),
        .saturated     (saturated),
        .size_error    (size_error)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Euclidean point distance with FRAC_BITS fraction bits, by integer root
    function automatic logic [63:0] point_distance(point_t p, point_t q);
        longint dx;
        longint dy;
        logic [63:0] radicand;
        logic [63:0] root;
        logic [63:0] trial;
        dx = longint'(p.x) - longint'(q.x);
        dy = longint'(p.y) - longint'(q.y);
        radicand = 64'(dx * dx + dy * dy) << (2 * FRAC_BITS);
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    // Fill the warping table row by row and return the corner cell
    function automatic logic [DIST_W-1:0] warp_table();
        logic [63:0] diag;
        logic [63:0] up;
        logic [63:0] least_cell;
        logic [63:0] total;
        cost_cells[0] = CELL_ZERO;
        for (int j = 1; j <= num_b; j++)
            cost_cells[j] = UNREACHABLE;
        for (int i = 0; i < num_a; i++)
        begin
            diag = 64'(cost_cells[0]);
            cost_cells[0] = UNREACHABLE;
            for (int j = 1; j <= num_b; j++)
            begin
                up = 64'(cost_cells[j]);
                least_cell = up;
                if (64'(cost_cells[j-1]) < least_cell)
                    least_cell = 64'(cost_cells[j-1]);
                if (diag < least_cell)
                    least_cell = diag;
                total = point_distance(store_a[i], store_b[j-1]) + least_cell;
                diag = up;
                cost_cells[j] = (total > 64'(DIST_MAX)) ? DIST_MAX : CELL_W'(total);
            end
        end
        return cost_cells[num_b][DIST_W-1:0];
    endfunction

    // Update the model with one accepted point; report whether a result follows
    function automatic bit model_point(logic op, point_t pt, logic last,
                                       output warp_result_t res);
        res = '0;
        if (op == OP_A)
        begin
            if (!a_done)
            begin
                if (num_a < MAX_LEN)
                begin
                    store_a[num_a] = pt;
                    num_a++;
                end
                else
                    overflow_seen = 1;
                if (last)
                    a_done = 1;
            end
            return 0;
        end
        if (num_b < MAX_LEN)
        begin
            store_b[num_b] = pt;
            num_b++;
        end
        else
            overflow_seen = 1;
        if (!last)
            return 0;
        if (num_a == 0 || num_b == 0 || overflow_seen)
            res.err = 1'b1;
        else
        begin
            res.distance = warp_table();
            res.sat = (res.distance == {DIST_W{1'b1}});
        end
        num_a = 0;
        num_b = 0;
        a_done = 0;
        overflow_seen = 0;
        return 1;
    endfunction

    // Offer one point until accepted, then push the expected result if one follows
    task automatic send_point(logic op, logic [15:0] x, logic [15:0] y, logic last,
                              logic typed = 1'b0, logic [DIST_W-1:0] tdist = '0,
                              logic terr = 1'b0);
        warp_result_t res;
        point_t pt;
        while (!quiet && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        coord_x    <= x;
        coord_y    <= y;
        last_point <= last;
        do
            @(posedge clk);
        while (in_stall);
        pt.x = x;
        pt.y = y;
        if (model_point(op, pt, last, res))
        begin
            if (typed)
            begin
                res.distance = tdist;
                res.sat = 1'b0;
                res.err = terr;
            end
            expected_q.push_back(res);
        end
    endtask

    function automatic logic [15:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
        if (pick < 5)
            return 16'($signed($urandom_range(64)) - 32);
        return 16'($urandom);
    endfunction

    task automatic send_trajectory(logic op, int len);
        for (int k = 0; k < len; k++)
            send_point(op, rand_coord(), rand_coord(), k == len - 1);
    endtask

    // Result side: random stall, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_count <= 0;
        end
        else if (hold_off_req && stall_count < HOLD_OFF_CYCLES)
        begin
            out_stall   <= 1'b1;
            stall_count <= stall_count + 1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 17);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        warp_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result dist=%0d sat=%0b err=%0b", $time,
                         warp_distance, saturated, size_error);
                mismatches++;
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (warp_distance !== exp_res.distance)
                begin
                    $display("%0t: warp_distance expected %0d actual %0d", $time,
                             exp_res.distance, warp_distance);
                    mismatches++;
                end
                if (saturated !== exp_res.sat)
                begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             exp_res.sat, saturated);
                    mismatches++;
                end
                if (size_error !== exp_res.err)
                begin
                    $display("%0t: size_error expected %0b actual %0b", $time,
                             exp_res.err, size_error);
                    mismatches++;
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int sent;
        int len_a;
        int len_b;
        bit drained;
        stim_row_t row;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_A;
        coord_x       = '0;
        coord_y       = '0;
        last_point    = 1'b0;
        quiet         = 0;
        hold_off_req  = 0;
        drained       = 0;
        num_a         = 0;
        num_b         = 0;
        a_done        = 0;
        overflow_seen = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int r = 0; r < 17; r++)
        begin
            row = dir_tab[r];
            send_point(row.op, row.x, row.y, row.last, row.typed, row.distance, row.err);
        end

        // overflow A, then overflow B, both give an error result
        for (int k = 0; k <= MAX_LEN; k++)
            send_point(OP_A, 16'(k), 16'(-k), k == MAX_LEN);
        send_point(OP_B, 16'h0001, 16'h0002, 1'b1, 1'b1, '0, 1'b1);
        send_point(OP_A, 16'h0005, 16'h0006, 1'b1);
        for (int k = 0; k <= MAX_LEN; k++)
            send_point(OP_B, 16'(k), 16'(k), k == MAX_LEN, k == MAX_LEN, '0, 1'b1);

        // one full-length A against a single B point
        send_trajectory(OP_A, MAX_LEN);
        send_trajectory(OP_B, 1);

        // random trajectories, mostly well formed
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = (sent >= 100 && sent < 200);
            if (sent >= 250 && !hold_off_req)
                hold_off_req = 1;
            if (sent >= 350 && !drained)
            begin
                // pause the sender until every result is back
                in_valid <= 1'b0;
                wait (expected_q.size() == 0);
                @(posedge clk);
                drained = 1;
            end
            len_a = ($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
            len_b = ($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
            case ($urandom_range(9))
                0:
                begin
                    // B before A, then a stray A point after A's last
                    send_point(OP_B, rand_coord(), rand_coord(), 1'b0);
                    send_trajectory(OP_A, len_a);
                    send_point(OP_A, rand_coord(), rand_coord(), $urandom_range(1));
                    send_trajectory(OP_B, len_b);
                    sent += len_a + len_b + 2;
                end
                1:
                begin
                    // empty A
                    send_trajectory(OP_B, len_b);
                    sent += len_b;
                end
                default:
                begin
                    send_trajectory(OP_A, len_a);
                    send_trajectory(OP_B, len_b);
                    sent += len_a + len_b;
                end
            endcase
        end

        in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dtwd_pkg.sv
hw/rtl/dtwd_ram.sv
hw/rtl/dtwd_dist.sv
hw/rtl/dtw_distance_2d_core.sv
sim/tb_dtw_distance_2d_core.sv
